>>> rtl/core/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared constants and types of the lidar packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int PACKET_BYTES       = 22;
    localparam int SAMPLES_PER_PACKET = 4;
    localparam int QUEUE_DEPTH        = 2;

    localparam int POS_W    = $clog2(PACKET_BYTES);
    localparam int SAMPLE_W = $clog2(SAMPLES_PER_PACKET);
    localparam int ANGLE_W  = 9;
    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;

    localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(PACKET_BYTES - 1);
    localparam logic [BYTE_W-1:0] START_BYTE  = 8'hFA;
    localparam logic [BYTE_W-1:0] INDEX_LOW   = 8'hA0;
    localparam logic [BYTE_W-1:0] INDEX_HIGH  = 8'hF9;
    localparam logic [WORD_W-1:0] RANGE_RESET = 16'd15000;

    localparam int SPEED_POS  = 2;
    localparam int SAMPLE_POS = 4;

    typedef struct packed {
        logic [ANGLE_W-1:0]                        angle_first;
        logic [WORD_W-1:0]                         speed;
        logic [SAMPLES_PER_PACKET-1:0][WORD_W-1:0] distance;
        logic [SAMPLES_PER_PACKET-1:0][WORD_W-1:0] refl;
    } pkt_t;

endpackage

>>> rtl/core/lpd_front.sv
// ----------------------------------------------------------------------------
// lpd_front
// Hunts for the start byte, collects the packet bytes and pushes one
// decoded packet per good index.
// ----------------------------------------------------------------------------
module lpd_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lpd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       q_full,
    output logic                       q_push,
    output lpd_pkg::pkt_t              q_data
);

    logic [lpd_pkg::POS_W-1:0]  pos_reg;
    logic [lpd_pkg::POS_W-1:0]  pos_next;
    logic [lpd_pkg::BYTE_W-1:0] bytes_reg [lpd_pkg::PACKET_BYTES];
    logic                       accept;
    logic                       hunting;
    logic                       at_end;
    logic                       idx_ok;
    logic [lpd_pkg::BYTE_W-1:0] idx;
    logic [lpd_pkg::BYTE_W-1:0] idx_off;

    assign hunting  = (pos_reg == '0);
    assign at_end   = (pos_reg == lpd_pkg::LAST_POS);
    assign in_stall = at_end && q_full;
    assign accept   = in_valid && !in_stall;

    assign idx     = bytes_reg[1];
    assign idx_ok  = (idx >= lpd_pkg::INDEX_LOW) && (idx <= lpd_pkg::INDEX_HIGH);
    assign idx_off = idx - lpd_pkg::INDEX_LOW;
    assign q_push  = accept && at_end && idx_ok;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (hunting)
            begin
                if (rx_byte == lpd_pkg::START_BYTE)
                begin
                    pos_next = lpd_pkg::POS_W'(1);
                end
            end
            else if (at_end)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + lpd_pkg::POS_W'(1);
            end
        end
    end

    always_comb
    begin
        q_data.angle_first = {idx_off[lpd_pkg::ANGLE_W-3:0], 2'b00};
        q_data.speed       = {bytes_reg[lpd_pkg::SPEED_POS+1], bytes_reg[lpd_pkg::SPEED_POS]};
        for (int i = 0; i < lpd_pkg::SAMPLES_PER_PACKET; i++)
        begin
            q_data.distance[i] = {bytes_reg[lpd_pkg::SAMPLE_POS + 4*i + 1],
                                  bytes_reg[lpd_pkg::SAMPLE_POS + 4*i]};
            q_data.refl[i]     = {bytes_reg[lpd_pkg::SAMPLE_POS + 4*i + 3],
                                  bytes_reg[lpd_pkg::SAMPLE_POS + 4*i + 2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (!hunting || rx_byte == lpd_pkg::START_BYTE))
        begin
            bytes_reg[pos_reg] <= rx_byte;
        end
    end

endmodule

>>> rtl/core/lpd_queue.sv
// ----------------------------------------------------------------------------
// lpd_queue
// Short packet queue between the byte collector and the sample emitter.
// ----------------------------------------------------------------------------
module lpd_queue
#(
    parameter int DEPTH = lpd_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lpd_pkg::pkt_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output lpd_pkg::pkt_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpd_pkg::pkt_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/lpd_back.sv
// ----------------------------------------------------------------------------
// lpd_back
// Walks the four samples of the head packet into the output register and
// holds the range limit.
// ----------------------------------------------------------------------------
module lpd_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lpd_pkg::WORD_W-1:0]  cfg_wr_data,
    input  logic                        q_not_empty,
    input  lpd_pkg::pkt_t               q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lpd_pkg::ANGLE_W-1:0] angle_deg,
    output logic [lpd_pkg::WORD_W-1:0]  distance_mm,
    output logic [lpd_pkg::WORD_W-1:0]  reflection,
    output logic [lpd_pkg::WORD_W-1:0]  speed_raw,
    output logic                        sample_valid,
    output logic                        last
);

    localparam logic [lpd_pkg::SAMPLE_W-1:0] LAST_SAMPLE =
        lpd_pkg::SAMPLE_W'(lpd_pkg::SAMPLES_PER_PACKET - 1);

    logic [lpd_pkg::WORD_W-1:0]   max_range_reg;
    logic [lpd_pkg::SAMPLE_W-1:0] sample_reg;
    logic [lpd_pkg::SAMPLE_W-1:0] sample_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [lpd_pkg::ANGLE_W-1:0]  angle_reg;
    logic [lpd_pkg::WORD_W-1:0]   dist_reg;
    logic [lpd_pkg::WORD_W-1:0]   refl_reg;
    logic [lpd_pkg::WORD_W-1:0]   speed_reg;
    logic                         svalid_reg;
    logic                         last_reg;
    logic                         load;
    logic                         is_last;
    logic [lpd_pkg::WORD_W-1:0]   cur_dist;
    logic [lpd_pkg::WORD_W-1:0]   cur_refl;

    assign load     = q_not_empty && (!out_valid_reg || !out_stall);
    assign is_last  = (sample_reg == LAST_SAMPLE);
    assign q_pop    = load && is_last;
    assign cur_dist = q_head.distance[sample_reg];
    assign cur_refl = q_head.refl[sample_reg];

    always_comb
    begin
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            sample_next    = is_last ? '0 : sample_reg + lpd_pkg::SAMPLE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= lpd_pkg::RANGE_RESET;
            sample_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_range_reg <= cfg_wr_data;
            end
            sample_reg    <= sample_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            angle_reg  <= q_head.angle_first + lpd_pkg::ANGLE_W'(sample_reg);
            dist_reg   <= cur_dist;
            refl_reg   <= cur_refl;
            speed_reg  <= q_head.speed;
            svalid_reg <= (cur_refl != '0) && (cur_dist < max_range_reg);
            last_reg   <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign angle_deg    = angle_reg;
    assign distance_mm  = dist_reg;
    assign reflection   = refl_reg;
    assign speed_raw    = speed_reg;
    assign sample_valid = svalid_reg;
    assign last         = last_reg;

endmodule

>>> rtl/core/lidar_packet_deframer.sv
// ----------------------------------------------------------------------------
// lidar_packet_deframer
// Cuts the lidar byte stream into packets and emits four samples per packet.
// ----------------------------------------------------------------------------
// one byte accepted per cycle unless stalled; the finished packet is queued
// and its four samples enter the output register one per cycle, unless stalled
// the byte side stalls only on a packet's last byte while the packet queue
// is full; queue depth sets how many finished packets may wait
// reset clears the hunt position, the queue and the output valid, and loads
// the range limit with its default; packet bytes are not cleared
// ----------------------------------------------------------------------------
module lidar_packet_deframer
#(
    parameter int QUEUE_DEPTH = lpd_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lpd_pkg::WORD_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lpd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lpd_pkg::ANGLE_W-1:0] angle_deg,
    output logic [lpd_pkg::WORD_W-1:0]  distance_mm,
    output logic [lpd_pkg::WORD_W-1:0]  reflection,
    output logic [lpd_pkg::WORD_W-1:0]  speed_raw,
    output logic                        sample_valid,
    output logic                        last
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_not_empty;
    lpd_pkg::pkt_t q_in;
    lpd_pkg::pkt_t q_head;

    lpd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    lpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    lpd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .angle_deg    (angle_deg),
        .distance_mm  (distance_mm),
        .reflection   (reflection),
        .speed_raw    (speed_raw),
        .sample_valid (sample_valid),
        .last         (last)
    );

endmodule
